### hw/rtl/ctc_pkg.sv
// Shared types and constants for the coin template classifier.
// Holds the command and result transaction structs and the status codes.
// No dependencies.
package ctc_pkg;

	localparam int unsigned TEMPLATES_DEFAULT   = 3;
	localparam int unsigned MAX_SAMPLES_DEFAULT = 16;
	localparam int unsigned MIN_SAMPLES         = 5;

	localparam int unsigned DIAM_W = 16;
	localparam int unsigned EM_W   = 10;

	typedef enum logic [2:0] {
		ST_REJECT  = 3'd0,
		ST_ACCEPT  = 3'd1,
		ST_TAKEN   = 3'd2,
		ST_STORED  = 3'd3,
		ST_FEW     = 3'd4,
		ST_DROPPED = 3'd5
	} status_t;

	typedef enum logic {
		OP_CLASSIFY = 1'b0,
		OP_TRAIN    = 1'b1
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [1:0]        template_slot;
		logic [DIAM_W-1:0] diam_time;
		logic [EM_W-1:0]   em_level;
		logic              last_sample;
	} cmd_t;

	typedef struct packed {
		status_t    status;
		logic [1:0] matched_template;
	} result_t;

endpackage

### hw/rtl/coin_template_classifier.sv
// Coin template classifier: template scan, training sample buffer and template fit.
// Depends on ctc_pkg (transaction structs, status codes, default sizes).
// Single module: sequencer around one divider, one multiplier and one square-root step.
//
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ----------------------
// cmd       in         start high, busy low      ctc_pkg::cmd_t
// result    out        done strobe, one cycle    ctc_pkg::result_t
//
// Sequencing: a classify transaction raises busy, one template compare per cycle,
// stopping at the first template that fits; the result strobes as busy falls.
// A non-final training sample is stored at the accept edge and its result
// strobes the next cycle without raising busy, as does a dropped sample or a
// final one with too few samples. A template fit holds busy through two passes
// of a mean division, a read/subtract/square/add per buffered sample, a
// variance division (one quotient bit per cycle, 32 + count-width bits) and a
// 16-step square root.
// Reset clears templates, the sample count and the running totals; the sample
// buffer itself is never cleared, only entries below the count are read.
// The receiver cannot stall: every result is presented for exactly one cycle.
module coin_template_classifier #(
	parameter int unsigned TEMPLATES   = ctc_pkg::TEMPLATES_DEFAULT,
	parameter int unsigned MAX_SAMPLES = ctc_pkg::MAX_SAMPLES_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ctc_pkg::cmd_t     cmd,
	output logic              done,
	output ctc_pkg::result_t  result
);

	localparam int unsigned DIAM_W = ctc_pkg::DIAM_W;
	localparam int unsigned EM_W   = ctc_pkg::EM_W;
	localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned IDX_W  = $clog2(MAX_SAMPLES);
	localparam int unsigned TIDX_W = (TEMPLATES > 1) ? $clog2(TEMPLATES) : 1;
	localparam int unsigned DT_W   = DIAM_W + CNT_W;
	localparam int unsigned ET_W   = EM_W + CNT_W;
	localparam int unsigned SQ_W   = 2 * DIAM_W;
	localparam int unsigned ACC_W  = SQ_W + CNT_W;
	localparam int unsigned DCNT_W = $clog2(ACC_W);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLS,
		S_DIV,
		S_ACC_RD,
		S_ACC_DIFF,
		S_ACC_MUL,
		S_ACC_ADD,
		S_SQRT
	} state_t;

	typedef struct packed {
		logic [DIAM_W-1:0] diam;
		logic [EM_W-1:0]   em;
	} sample_t;

	function automatic logic [DIAM_W-1:0] absdiff(input logic [DIAM_W-1:0] a,
		input logic [DIAM_W-1:0] b);
		absdiff = (a > b) ? (a - b) : (b - a);
	endfunction

	// Templates
	logic [DIAM_W-1:0] tdm_q [TEMPLATES];
	logic [DIAM_W-1:0] tds_q [TEMPLATES];
	logic [EM_W-1:0]   tem_q [TEMPLATES];
	logic [EM_W-1:0]   tes_q [TEMPLATES];

	// Sample buffer
	sample_t           smem [MAX_SAMPLES];
	sample_t           rd_word_q;

	// Sequencer state
	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [DT_W-1:0]   dtot_q;
	logic [ET_W-1:0]   etot_q;
	logic [1:0]        slot_q;
	logic [TIDX_W-1:0] cls_idx_q;
	logic [DIAM_W-1:0] cdiam_q;
	logic [EM_W-1:0]   cem_q;
	logic              pass_q;
	logic              div_var_q;
	logic [ACC_W-1:0]  div_num_q;
	logic [CNT_W-1:0]  div_rem_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [DIAM_W-1:0] diff_q;
	logic [SQ_W-1:0]   sq_q;
	logic [ACC_W-1:0]  acc_q;
	logic [SQ_W-1:0]   sq_v_q;
	logic [SQ_W-1:0]   sq_res_q;
	logic [SQ_W-1:0]   sq_bit_q;
	logic [DIAM_W-1:0] dmean_q;
	logic [EM_W-1:0]   emean_q;
	logic [DIAM_W-1:0] dspread_q;
	logic              done_q;
	ctc_pkg::result_t  result_q;

	// Combinational helpers
	logic              accept;
	logic              slot_ok;
	logic              room;
	logic              wr_en;
	logic [CNT_W-1:0]  n_new;
	logic [DT_W-1:0]   dtot_new;
	logic [ET_W-1:0]   etot_new;
	logic [CNT_W:0]    trial;
	logic              trial_ge;
	logic [CNT_W-1:0]  rem_next;
	logic [ACC_W-1:0]  div_next;
	logic [DIAM_W-1:0] smp_val;
	logic [DIAM_W-1:0] mean_val;
	logic              rd_last;
	logic [ACC_W-1:0]  acc_next;
	logic [SQ_W-1:0]   sq_sum;
	logic              sq_ge;
	logic [SQ_W-1:0]   sq_res_next;
	logic [SQ_W-1:0]   sq_v_next;
	logic [DIAM_W-1:0] spread_val;
	logic              cls_hit;
	logic              cls_last;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;
	assign accept = start && !busy;

	always_comb begin
		// Training sample bookkeeping at the accept edge
		slot_ok  = ({30'd0, cmd.template_slot} < 32'(TEMPLATES));
		room     = (count_q < CNT_W'(MAX_SAMPLES));
		wr_en    = accept && (cmd.op == ctc_pkg::OP_TRAIN) && slot_ok && room;
		n_new    = count_q + CNT_W'(room);
		dtot_new = dtot_q + (room ? DT_W'(cmd.diam_time) : DT_W'(0));
		etot_new = etot_q + (room ? ET_W'(cmd.em_level) : ET_W'(0));

		// Restoring divider, one quotient bit per cycle, divisor is the count
		trial    = {div_rem_q, div_num_q[ACC_W-1]};
		trial_ge = (trial >= {1'b0, count_q});
		rem_next = trial_ge ? CNT_W'(trial - {1'b0, count_q}) : trial[CNT_W-1:0];
		div_next = {div_num_q[ACC_W-2:0], trial_ge};

		// Deviation accumulation
		smp_val  = pass_q ? DIAM_W'(rd_word_q.em) : rd_word_q.diam;
		mean_val = pass_q ? DIAM_W'(emean_q) : dmean_q;
		rd_last  = (CNT_W'(rd_idx_q) == (count_q - CNT_W'(1)));
		acc_next = acc_q + ACC_W'(sq_q);

		// Digit-by-digit square root step
		sq_sum      = sq_res_q + sq_bit_q;
		sq_ge       = (sq_v_q >= sq_sum);
		sq_v_next   = sq_ge ? (sq_v_q - sq_sum) : sq_v_q;
		sq_res_next = sq_ge ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);
		spread_val  = (sq_res_next == '0) ? DIAM_W'(1) : sq_res_next[DIAM_W-1:0];

		// Template compare
		cls_hit  = ({1'b0, absdiff(tdm_q[cls_idx_q], cdiam_q)}
			<= {tds_q[cls_idx_q], 1'b0})
			&& (absdiff(DIAM_W'(tem_q[cls_idx_q]), DIAM_W'(cem_q))
			<= DIAM_W'(tes_q[cls_idx_q]));
		cls_last = (cls_idx_q == TIDX_W'(TEMPLATES - 1));
	end

	// Sample buffer: one write port at the count, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			smem[count_q[IDX_W-1:0]] <= '{diam: cmd.diam_time, em: cmd.em_level};
		end
		rd_word_q <= smem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			dtot_q    <= '0;
			etot_q    <= '0;
			done_q    <= 1'b0;
			result_q  <= '{status: ctc_pkg::ST_REJECT, matched_template: 2'd0};
			for (int i = 0; i < TEMPLATES; i++) begin
				tdm_q[i] <= '0;
				tds_q[i] <= '0;
				tem_q[i] <= '0;
				tes_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						result_q.matched_template <= 2'd0;
						if (cmd.op == ctc_pkg::OP_CLASSIFY) begin
							// Hold the coin and scan from template zero
							cdiam_q   <= cmd.diam_time;
							cem_q     <= cmd.em_level;
							cls_idx_q <= '0;
							state_q   <= S_CLS;
						end else if (!slot_ok) begin
							done_q          <= 1'b1;
							result_q.status <= ctc_pkg::ST_DROPPED;
						end else if (!cmd.last_sample) begin
							count_q         <= n_new;
							dtot_q          <= dtot_new;
							etot_q          <= etot_new;
							done_q          <= 1'b1;
							result_q.status <= room ? ctc_pkg::ST_TAKEN : ctc_pkg::ST_DROPPED;
						end else if (n_new < CNT_W'(ctc_pkg::MIN_SAMPLES)) begin
							// Too few samples: report and drop the buffer
							count_q         <= '0;
							dtot_q          <= '0;
							etot_q          <= '0;
							done_q          <= 1'b1;
							result_q.status <= ctc_pkg::ST_FEW;
						end else begin
							// Start the fit with the diameter mean
							count_q   <= n_new;
							dtot_q    <= dtot_new;
							etot_q    <= etot_new;
							slot_q    <= cmd.template_slot;
							pass_q    <= 1'b0;
							div_var_q <= 1'b0;
							div_num_q <= ACC_W'(dtot_new);
							div_rem_q <= '0;
							div_cnt_q <= DCNT_W'(ACC_W - 1);
							state_q   <= S_DIV;
						end
					end
				end
				S_CLS: begin
					if (cls_hit) begin
						done_q   <= 1'b1;
						result_q <= '{status: ctc_pkg::ST_ACCEPT,
							matched_template: 2'(cls_idx_q)};
						state_q  <= S_IDLE;
					end else if (cls_last) begin
						done_q   <= 1'b1;
						result_q <= '{status: ctc_pkg::ST_REJECT, matched_template: 2'd0};
						state_q  <= S_IDLE;
					end else begin
						cls_idx_q <= cls_idx_q + TIDX_W'(1);
					end
				end
				S_DIV: begin
					div_num_q <= div_next;
					div_rem_q <= rem_next;
					div_cnt_q <= div_cnt_q - DCNT_W'(1);
					if (div_cnt_q == '0) begin
						if (!div_var_q) begin
							// Mean done: latch it and sweep the buffer
							if (pass_q) begin
								emean_q <= div_next[EM_W-1:0];
							end else begin
								dmean_q <= div_next[DIAM_W-1:0];
							end
							rd_idx_q <= '0;
							acc_q    <= '0;
							state_q  <= S_ACC_RD;
						end else begin
							sq_v_q   <= div_next[SQ_W-1:0];
							sq_res_q <= '0;
							sq_bit_q <= SQ_W'(1) << (SQ_W - 2);
							state_q  <= S_SQRT;
						end
					end
				end
				S_ACC_RD: begin
					state_q <= S_ACC_DIFF;
				end
				S_ACC_DIFF: begin
					diff_q  <= absdiff(smp_val, mean_val);
					state_q <= S_ACC_MUL;
				end
				S_ACC_MUL: begin
					sq_q    <= diff_q * diff_q;
					state_q <= S_ACC_ADD;
				end
				S_ACC_ADD: begin
					acc_q <= acc_next;
					if (rd_last) begin
						div_var_q <= 1'b1;
						div_num_q <= acc_next;
						div_rem_q <= '0;
						div_cnt_q <= DCNT_W'(ACC_W - 1);
						state_q   <= S_DIV;
					end else begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
						state_q  <= S_ACC_RD;
					end
				end
				S_SQRT: begin
					sq_v_q   <= sq_v_next;
					sq_res_q <= sq_res_next;
					sq_bit_q <= sq_bit_q >> 2;
					if (sq_bit_q[0]) begin
						if (!pass_q) begin
							// Diameter spread done: advance to the level pass
							dspread_q <= spread_val;
							pass_q    <= 1'b1;
							div_var_q <= 1'b0;
							div_num_q <= ACC_W'(etot_q);
							div_rem_q <= '0;
							div_cnt_q <= DCNT_W'(ACC_W - 1);
							state_q   <= S_DIV;
						end else begin
							tdm_q[TIDX_W'(slot_q)] <= dmean_q;
							tds_q[TIDX_W'(slot_q)] <= dspread_q;
							tem_q[TIDX_W'(slot_q)] <= emean_q;
							tes_q[TIDX_W'(slot_q)] <= spread_val[EM_W-1:0];
							count_q  <= '0;
							dtot_q   <= '0;
							etot_q   <= '0;
							done_q   <= 1'b1;
							result_q <= '{status: ctc_pkg::ST_STORED, matched_template: 2'd0};
							state_q  <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A result is never strobed while a transaction is still in work
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	// Busy only rises on an accepted transaction
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start");

	// Every busy period ends with exactly its result
	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result");

	// The fit only runs with enough buffered samples
	a_fit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (count_q >= CNT_W'(ctc_pkg::MIN_SAMPLES)))
		else $error("fit running with too few samples");

endmodule

### dv/coin_template_classifier_tb.sv
// Self-checking testbench for coin_template_classifier: directed and random coin transactions.
// Predicts each verdict with its own template store and sample buffer, then checks every strobe.
// Depends on ctc_pkg and the coin_template_classifier RTL only.
module coin_template_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ctc_pkg::*;

	localparam int unsigned TEMPLATES   = TEMPLATES_DEFAULT;
	localparam int unsigned MAX_SAMPLES = MAX_SAMPLES_DEFAULT;
	localparam int unsigned ITEMS       = 1500;
	localparam int unsigned DIAM_TOP    = 65535;
	localparam int unsigned EM_TOP      = 1023;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	cmd_t    cmd = '0;
	logic    busy;
	logic    done;
	result_t result;

	coin_template_classifier dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	// Coins waiting to be driven, and verdicts waiting for their strobe.
	cmd_t    coin_feed[$];
	result_t pending_verdicts[$];

	int unsigned coins_accepted = 0;
	int unsigned fault_count = 0;
	int unsigned cycle_count = 0;
	int unsigned cycle_limit = 32'hFFFF_FFFF;
	result_t     due;

	// Shadow of the block: template table, sample buffer and exact running sums.
	logic [15:0]       fit_diam_mean[TEMPLATES]   = '{default: '0};
	logic [15:0]       fit_diam_spread[TEMPLATES] = '{default: '0};
	logic [9:0]        fit_em_mean[TEMPLATES]     = '{default: '0};
	logic [9:0]        fit_em_spread[TEMPLATES]   = '{default: '0};
	logic [15:0]       buf_diam[MAX_SAMPLES];
	logic [9:0]        buf_em[MAX_SAMPLES];
	int unsigned       buf_count = 0;
	longint unsigned   diam_sum = 0;
	longint unsigned   em_sum = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic cmd_t make_cmd(op_t op, logic [1:0] slot, int unsigned diam,
			int unsigned em, logic last);
		cmd_t c;
		c.op            = op;
		c.template_slot = slot;
		c.diam_time     = diam[15:0];
		c.em_level      = em[9:0];
		c.last_sample   = last;
		return c;
	endfunction

	// Pick a value within reach of center, clamped to the field range.
	function automatic int unsigned scatter(int unsigned center, int unsigned reach,
			int unsigned top);
		int v;
		v = int'(center) + int'($urandom_range(2 * reach)) - int'(reach);
		if (v < 0)
			v = 0;
		if (v > int'(top))
			v = top;
		return v;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	// Floor root of the floor mean squared deviation over the buffer, never below 1.
	function automatic logic [15:0] rms_spread(logic use_diam, longint unsigned mean);
		longint unsigned acc;
		longint unsigned x;
		longint unsigned d;
		longint unsigned r;
		acc = 0;
		for (int i = 0; i < buf_count; i++) begin
			x = use_diam ? buf_diam[i] : buf_em[i];
			d = (x > mean) ? x - mean : mean - x;
			acc += d * d;
		end
		r = floor_sqrt(acc / buf_count);
		if (r < 1)
			r = 1;
		return r[15:0];
	endfunction

	function automatic logic coin_fits(int unsigned t, cmd_t c);
		int unsigned dd;
		int unsigned de;
		dd = (fit_diam_mean[t] > c.diam_time) ? fit_diam_mean[t] - c.diam_time
			: c.diam_time - fit_diam_mean[t];
		de = (fit_em_mean[t] > c.em_level) ? fit_em_mean[t] - c.em_level
			: c.em_level - fit_em_mean[t];
		return (dd <= 2 * int'(fit_diam_spread[t])) && (de <= int'(fit_em_spread[t]));
	endfunction

	// Advance the shadow by one accepted transaction and queue its verdict.
	task automatic predict_verdict(cmd_t c);
		result_t     v;
		logic        kept;
		int unsigned dmean;
		int unsigned emean;
		v.status           = ST_REJECT;
		v.matched_template = '0;
		if (c.op == OP_CLASSIFY) begin
			// Scan in index order; the first template that fits wins.
			for (int t = 0; t < TEMPLATES; t++) begin
				if (v.status == ST_REJECT && coin_fits(t, c)) begin
					v.status           = ST_ACCEPT;
					v.matched_template = t[1:0];
				end
			end
		end else if (c.template_slot >= TEMPLATES) begin
			v.status = ST_DROPPED;
		end else begin
			kept = 1'b0;
			if (buf_count < MAX_SAMPLES) begin
				buf_diam[buf_count] = c.diam_time;
				buf_em[buf_count]   = c.em_level;
				diam_sum += c.diam_time;
				em_sum   += c.em_level;
				buf_count++;
				kept = 1'b1;
			end
			if (!c.last_sample) begin
				v.status = kept ? ST_TAKEN : ST_DROPPED;
			end else begin
				if (buf_count < MIN_SAMPLES) begin
					v.status = ST_FEW;
				end else begin
					// The slot of the final sample picks the template to write.
					dmean = 32'(diam_sum / buf_count);
					emean = 32'(em_sum / buf_count);
					fit_diam_spread[c.template_slot] = rms_spread(1'b1, dmean);
					fit_em_spread[c.template_slot]   = 10'(rms_spread(1'b0, emean));
					fit_diam_mean[c.template_slot]   = dmean[15:0];
					fit_em_mean[c.template_slot]     = emean[9:0];
					v.status = ST_STORED;
				end
				buf_count = 0;
				diam_sum  = 0;
				em_sum    = 0;
			end
		end
		pending_verdicts.push_back(v);
	endtask

	task automatic log_fault(string what, logic [15:0] want, logic [15:0] got);
		fault_count++;
		if (fault_count <= 10)
			$display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	// Driver: a transaction completes on an edge with start high and busy low.
	// Hold the command while busy; otherwise load the next coin or idle now and then.
	// The idle draw is skipped for a stretch in the middle so back-to-back traffic happens too.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd   <= '0;
		end else begin
			if (start && !busy) begin
				predict_verdict(cmd);
				coins_accepted++;
			end
			if (!start || !busy) begin
				if (coin_feed.size() > 0 && ((coins_accepted >= 600 && coins_accepted < 900)
						|| $urandom_range(99) >= 14)) begin
					cmd   <= coin_feed.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobe must match the oldest pending verdict, field by field.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_verdicts.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("[%0t] result strobe with no transaction pending, status %0d",
						$time, result.status);
			end else begin
				due = pending_verdicts.pop_front();
				if (result.status !== due.status)
					log_fault("status", due.status, result.status);
				if (result.matched_template !== due.matched_template)
					log_fault("matched_template", due.matched_template,
						result.matched_template);
			end
		end
	end

	// Watchdog: drop the run if traffic stops moving.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > cycle_limit) begin
			$display("coin_template_classifier test failed");
			$finish;
		end
	end

	initial begin
		int unsigned pick;
		int unsigned len;
		int unsigned t;
		int unsigned slot;
		int unsigned wide;
		int unsigned cd;
		int unsigned ce;
		int unsigned jd;
		int unsigned je;
		int unsigned center_d[TEMPLATES];
		int unsigned center_e[TEMPLATES];
		int unsigned reach_d[TEMPLATES];
		int unsigned reach_e[TEMPLATES];

		for (int i = 0; i < TEMPLATES; i++) begin
			center_d[i] = 0;
			center_e[i] = 0;
			reach_d[i]  = 2;
			reach_e[i]  = 2;
		end

		// Reset templates: only the all-zero coin matches, at template 0.
		coin_feed.push_back(make_cmd(OP_CLASSIFY, 2'd3, 0, 0, 1'b1));
		coin_feed.push_back(make_cmd(OP_CLASSIFY, 2'd0, 1, 0, 1'b0));
		coin_feed.push_back(make_cmd(OP_CLASSIFY, 2'd0, 0, 1, 1'b0));
		coin_feed.push_back(make_cmd(OP_CLASSIFY, 2'd1, DIAM_TOP, EM_TOP, 1'b0));
		// Slot out of range drops the sample, final or not.
		coin_feed.push_back(make_cmd(OP_TRAIN, 2'd3, 1234, 321, 1'b0));
		coin_feed.push_back(make_cmd(OP_TRAIN, 2'd3, 1234, 321, 1'b1));
		// A lone final sample: too few samples, buffer clears.
		coin_feed.push_back(make_cmd(OP_TRAIN, 2'd1, 777, 77, 1'b1));
		// Extreme fit into slot 2; earlier slots are ignored, a classify sits mid-run.
		coin_feed.push_back(make_cmd(OP_TRAIN, 2'd0, DIAM_TOP, EM_TOP, 1'b0));
		coin_feed.push_back(make_cmd(OP_TRAIN, 2'd1, 0, 0, 1'b0));
		coin_feed.push_back(make_cmd(OP_CLASSIFY, 2'd0, DIAM_TOP, EM_TOP, 1'b0));
		coin_feed.push_back(make_cmd(OP_TRAIN, 2'd0, DIAM_TOP, EM_TOP, 1'b0));
		coin_feed.push_back(make_cmd(OP_TRAIN, 2'd1, 0, 0, 1'b0));
		coin_feed.push_back(make_cmd(OP_TRAIN, 2'd2, DIAM_TOP, 512, 1'b1));
		coin_feed.push_back(make_cmd(OP_CLASSIFY, 2'd0, 32768, 600, 1'b0));
		// Identical samples: zero deviation, spread floors at 1.
		for (int i = 0; i < 5; i++)
			coin_feed.push_back(make_cmd(OP_TRAIN, 2'd0, 1000, 300, i == 4));
		coin_feed.push_back(make_cmd(OP_CLASSIFY, 2'd0, 1002, 301, 1'b0));
		coin_feed.push_back(make_cmd(OP_CLASSIFY, 2'd0, 1003, 300, 1'b0));

		// Random part: mostly training runs and coin bursts near trained templates,
		// the rest raw noise. Runs that overfill or underfill the buffer are mixed in.
		while (coin_feed.size() < ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				slot = $urandom_range(TEMPLATES - 1);
				pick = $urandom_range(99);
				len  = (pick < 70) ? $urandom_range(16, 5)
					: (pick < 85) ? $urandom_range(4, 1) : $urandom_range(20, 17);
				wide = ($urandom_range(9) == 0);
				cd = wide ? $urandom_range(DIAM_TOP) : $urandom_range(60000, 500);
				ce = wide ? $urandom_range(EM_TOP) : $urandom_range(980, 40);
				jd = wide ? DIAM_TOP : $urandom_range(400);
				je = wide ? EM_TOP : $urandom_range(30);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(9) == 0) begin
						t = $urandom_range(TEMPLATES - 1);
						coin_feed.push_back(make_cmd(OP_CLASSIFY, 2'($urandom_range(3)),
							scatter(center_d[t], reach_d[t], DIAM_TOP),
							scatter(center_e[t], reach_e[t], EM_TOP),
							1'($urandom_range(1))));
					end
					if (k == len - 1)
						t = slot;
					else
						t = ($urandom_range(19) == 0) ? 3 : $urandom_range(TEMPLATES - 1);
					coin_feed.push_back(make_cmd(OP_TRAIN, 2'(t), scatter(cd, jd, DIAM_TOP),
						scatter(ce, je, EM_TOP), k == len - 1));
				end
				center_d[slot] = cd;
				center_e[slot] = ce;
				reach_d[slot]  = 2 * jd + 2;
				reach_e[slot]  = je + 2;
			end else if (pick < 85) begin
				len = $urandom_range(8, 1);
				for (int k = 0; k < len; k++) begin
					t = $urandom_range(TEMPLATES - 1);
					if ($urandom_range(3) == 0)
						coin_feed.push_back(make_cmd(OP_CLASSIFY, 2'($urandom_range(3)),
							$urandom_range(DIAM_TOP), $urandom_range(EM_TOP),
							1'($urandom_range(1))));
					else
						coin_feed.push_back(make_cmd(OP_CLASSIFY, 2'($urandom_range(3)),
							scatter(center_d[t], reach_d[t], DIAM_TOP),
							scatter(center_e[t], reach_e[t], EM_TOP),
							1'($urandom_range(1))));
				end
			end else begin
				coin_feed.push_back(make_cmd(op_t'($urandom_range(1)),
					2'($urandom_range(3)), $urandom_range(DIAM_TOP),
					$urandom_range(EM_TOP), 1'($urandom_range(1))));
			end
		end

		// Allow every coin the time of a template fit, several times over.
		cycle_limit = coin_feed.size() * 1200 + 20000;
		len = coin_feed.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (coins_accepted < len)
			@(posedge clk);
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		if (fault_count == 0)
			$display("coin_template_classifier test passed");
		else
			$display("coin_template_classifier test failed");
		$finish;
	end

endmodule
